FILE: hdl/rmdc_pkg.sv
// rmdc_pkg: shared widths, register map and divider result type for the
// running-mean DC offset remover. No dependencies.
package rmdc_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COUNT_BITS   = 17;
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(100000);

  // register index taken from paddr[2]
  localparam logic REG_FIXED_OFFSET = 1'b0;
  localparam logic REG_WINDOW_LIMIT = 1'b1;

  typedef struct packed {
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] quot;
  } div_result_t;

endpackage

FILE: hdl/rmdc_serdiv.sv
// rmdc_serdiv: bit-serial restoring divider, signed sum over unsigned count,
// quotient truncated toward zero. Depends on rmdc_pkg.
module rmdc_serdiv import rmdc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_BITS-1:0] dividend_i,
  input  logic [COUNT_BITS-1:0]      divisor_i,   // held stable while dividing
  output div_result_t                result_o
);

  logic [SUM_BITS-1:0]     dvd_q;   // dividend bits out at top, quotient in at bottom
  logic [COUNT_BITS-1:0]   rem_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    busy_q;
  logic                    neg_q;
  logic                    done_q;
  logic [SAMPLE_BITS-1:0]  quot_q;

  logic [COUNT_BITS:0]     trial;
  logic                    qbit;
  logic [COUNT_BITS-1:0]   rem_d;
  logic [SUM_BITS-1:0]     dvd_d;
  logic [SUM_BITS-1:0]     mag;

  assign mag   = dividend_i[SUM_BITS-1] ? SUM_BITS'(-dividend_i) : SUM_BITS'(dividend_i);
  assign trial = {rem_q, dvd_q[SUM_BITS-1]};
  assign qbit  = (trial >= {1'b0, divisor_i});
  assign rem_d = qbit ? COUNT_BITS'(trial - {1'b0, divisor_i}) : COUNT_BITS'(trial);
  assign dvd_d = {dvd_q[SUM_BITS-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_BITS'(SUM_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag;
      rem_q <= '0;
      neg_q <= dividend_i[SUM_BITS-1];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      if (cnt_q == '0) begin
        // magnitude fits the sample width, so truncation before negate is exact
        quot_q <= neg_q ? SAMPLE_BITS'(-dvd_d[SAMPLE_BITS-1:0]) : dvd_d[SAMPLE_BITS-1:0];
      end
    end
  end

  assign result_o.done = done_q;
  assign result_o.quot = quot_q;

endmodule

FILE: hdl/running_mean_dc_offset_remover.sv
// running_mean_dc_offset_remover: top level, register file, accumulator,
// control and output saturation. Depends on rmdc_pkg and rmdc_serdiv.
//
//  channel   dir  handshake             payload
//  input     in   in_valid_i/in_ready_o sample_i (24b signed Q1.23)
//  output    out  out_valid_o/out_ready_i corrected_o (24b signed Q1.23, sat.)
//  config    in   APB psel/penable      paddr/pwdata/prdata, pready tied high
//
// Steps per accumulating item, accept included, up to out_valid_o:
// accept, divider load, 41 divider steps (one quotient bit each), quotient
// handoff, output load. A window clear has only accept and output load.
// One item in flight; in_ready_o rises once the result is in the output register.
// A stalled output holds the finished item in DONE until the register frees.
// Reset: fixed_offset 0, window_limit 100000, sum, count and mean cleared.
module running_mean_dc_offset_remover import rmdc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // output stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] corrected_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_e;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  state_e state_q;

  // configuration registers
  logic signed [SAMPLE_BITS-1:0] offset_q;
  logic [COUNT_BITS-1:0]         limit_q;

  // running state
  logic signed [SUM_BITS-1:0]    sum_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic signed [SAMPLE_BITS-1:0] mean_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // output register
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic signed [SAMPLE_BITS-1:0] corrected_q;

  logic                          cfg_wr;
  logic                          in_xact;
  logic                          out_free;
  logic                          load_out;
  logic signed [SUM_BITS-1:0]    sum_d;
  logic signed [SAMPLE_BITS:0]   ext_sum;
  logic signed [SAMPLE_BITS-1:0] result;
  div_result_t                   div_res;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // register index is paddr[2]; every address maps to one of the two registers
  always_comb begin
    unique case (paddr[2])
      REG_FIXED_OFFSET: prdata = DATA_BITS'(offset_q);   // sign-extended
      REG_WINDOW_LIMIT: prdata = DATA_BITS'(limit_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      limit_q  <= WINDOW_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIXED_OFFSET: offset_q <= pwdata[SAMPLE_BITS-1:0];
        REG_WINDOW_LIMIT: limit_q  <= pwdata[COUNT_BITS-1:0];
        default:          ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xact     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign load_out    = (state_q == S_DONE) & out_free;
  // a load wins over the drain of the previous transaction in the same cycle
  assign out_valid_d = load_out | (out_valid_q & ~out_ready_i);
  assign sum_d       = sum_q + {{COUNT_BITS{sample_i[SAMPLE_BITS-1]}}, sample_i};

  // fixed offset when programmed, else running-mean subtraction; one extra bit
  // catches overflow, which clamps to the nearest end of the range
  always_comb begin
    if (offset_q != '0) begin
      ext_sum = {sample_q[SAMPLE_BITS-1], sample_q} + {offset_q[SAMPLE_BITS-1], offset_q};
    end else begin
      ext_sum = {sample_q[SAMPLE_BITS-1], sample_q} - {mean_q[SAMPLE_BITS-1], mean_q};
    end
    if (ext_sum[SAMPLE_BITS] != ext_sum[SAMPLE_BITS-1]) begin
      result = ext_sum[SAMPLE_BITS] ? SMIN : SMAX;
    end else begin
      result = ext_sum[SAMPLE_BITS-1:0];
    end
  end

  rmdc_serdiv u_serdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_LOAD),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .result_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_xact) begin
            if (count_q < limit_q) begin
              sum_q   <= sum_d;
              count_q <= count_q + 1'b1;
              state_q <= S_LOAD;
            end else begin
              // window full: restart accumulation, mean holds
              sum_q   <= '0;
              count_q <= '0;
              state_q <= S_DONE;
            end
          end
        end
        S_LOAD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            mean_q  <= div_res.quot;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      sample_q <= sample_i;
    end
    if (load_out) begin
      corrected_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corrected_o = corrected_q;

endmodule

FILE: hdl/rmdc_checker.sv
// rmdc_checker: port-level assertions for the DC offset remover, bound to the
// top level. Depends on rmdc_pkg.
module rmdc_checker import rmdc_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] corrected_o,
  input logic                          pready
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corrected_o))
    else $error("output transaction dropped or changed under stall");

  // one item in flight: ready drops after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item in flight");

  // a new result returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result loaded but input not ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind running_mean_dc_offset_remover rmdc_checker u_rmdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .corrected_o (corrected_o),
  .pready      (pready)
);

FILE: verif/testbench.sv
// testbench: self-checking bench for running_mean_dc_offset_remover. Holds its own
// predictor, APB register driver and randomized valid/ready traffic.
// Depends on rmdc_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import rmdc_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam sample_t S_MAX = sample_t'(SAT_HI);
  localparam sample_t S_MIN = sample_t'(SAT_LO);
  localparam int unsigned WIN_MAX = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS = 600;
  localparam int PRINT_CAP = 40;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  sample_t              sample_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  sample_t              corrected_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Shadow of the block's registers and accumulator state
  longint      offset_reg = 0;
  int unsigned win_limit = WINDOW_RESET;
  longint      acc_sum = 0;
  int unsigned acc_count = 0;
  longint      mean_level = 0;

  // Corrected samples still owed by the block, oldest first
  sample_t expected_corrected[$];
  int      mismatches = 0;
  // When set, neither side idles: back-to-back transactions
  bit      steady_flow = 1'b0;

  running_mean_dc_offset_remover u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .corrected_o (corrected_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic sample_t saturate(input longint v);
    if (v > SAT_HI) begin
      return S_MAX;
    end
    if (v < SAT_LO) begin
      return S_MIN;
    end
    return sample_t'(v);
  endfunction

  // Advance the accumulator by one sample and return the corrected value.
  // Below the window limit the sample accumulates and the mean is refreshed
  // (signed divide truncates toward zero); at or above it the window clears
  // and the previous mean is held.
  function automatic sample_t remove_dc(input sample_t smp);
    longint s;
    s = longint'(smp);
    if (acc_count < win_limit) begin
      acc_sum += s;
      acc_count++;
      mean_level = acc_sum / longint'(acc_count);
    end else begin
      acc_sum = 0;
      acc_count = 0;
    end
    if (offset_reg != 0) begin
      return saturate(s + offset_reg);
    end
    return saturate(s - mean_level);
  endfunction

  // One input transaction. Valid stays high across back-to-back items and is
  // only lowered when a gap is drawn. Prediction happens at acceptance.
  task automatic send_sample(input sample_t smp);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    expected_corrected.push_back(remove_dc(smp));
  endtask

  // Stop sending and wait for every owed result; every sample yields one
  // result, so the block is idle once the queue drains.
  task automatic wait_results_drained;
    in_valid_i <= 1'b0;
    while (expected_corrected.size() != 0) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_register(input logic reg_sel, input logic [DATA_BITS-1:0] data);
    logic [DATA_BITS-1:0] rd;
    logic [DATA_BITS-1:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({reg_sel, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == REG_FIXED_OFFSET) begin
      offset_reg = longint'($signed(data[SAMPLE_BITS-1:0]));
      mask = (DATA_BITS'(1) << SAMPLE_BITS) - 1;
    end else begin
      win_limit = data[COUNT_BITS-1:0];
      mask = (DATA_BITS'(1) << COUNT_BITS) - 1;
    end
    // read phase, back to back with the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) != (data & mask)) begin
      report_mismatch($sformatf("readback reg %0d: got 0x%0h, wrote 0x%0h",
                                reg_sel, rd & mask, data & mask));
    end
  endtask

  task automatic set_offset(input sample_t off);
    write_register(REG_FIXED_OFFSET, {8'($urandom()), off});
  endtask

  task automatic set_window(input int unsigned lim);
    write_register(REG_WINDOW_LIMIT,
                   {15'($urandom()), lim[COUNT_BITS-1:0]});
  endtask

  // Result side: stall for a random number of cycles before each transaction
  initial begin : drive_out_ready
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_corrected.size() == 0) begin
        report_mismatch($sformatf("unexpected corrected %0d", corrected_o));
      end else begin
        want = expected_corrected.pop_front();
        if (corrected_o !== want) begin
          report_mismatch($sformatf("corrected: got %0d, want %0d", corrected_o, want));
        end
      end
    end
  end

  // Reset defaults: running-mean subtraction, saturation at both rails and
  // truncation of a negative mean.
  task automatic test_mean_tracking;
    sample_t seq[$];
    seq = '{0, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, -1, 1};
    foreach (seq[i]) send_sample(seq[i]);
    wait_results_drained();
  endtask

  // Nonzero fixed offset bypasses the mean; sums saturate.
  task automatic test_fixed_offset;
    set_offset(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(0);
    wait_results_drained();
    set_offset(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);
    wait_results_drained();
    set_offset(1);
    send_sample(-1);
    wait_results_drained();
    set_offset(0);
  endtask

  // Window of one, window of zero (always clears), limit lowered below the
  // current count, and the largest window.
  task automatic test_window_limits;
    set_window(1);
    send_sample(S_MAX);
    send_sample(-5);
    send_sample(S_MIN);
    wait_results_drained();
    set_window(0);
    send_sample(1234);
    send_sample(S_MAX);
    wait_results_drained();
    set_window(4);
    send_sample(-7);
    send_sample(100);
    send_sample(-3);
    wait_results_drained();
    set_window(2);   // count is already above the new limit
    send_sample(50);
    send_sample(-9);
    wait_results_drained();
    set_window(WIN_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    wait_results_drained();
  endtask

  // Audio-like content: a DC level with noise, plus rail hits and raw noise
  function automatic sample_t pick_sample(input sample_t dc);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2, 3: return sample_t'($urandom());
      default: return saturate(longint'(dc) + longint'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Phases of random traffic, each under a fresh register setting.
  // Window carries its count over, so shrinking windows hit the clear path.
  task automatic test_random_traffic;
    int      sent;
    int      n;
    sample_t dc;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: set_window(1);
        1: set_window($urandom_range(2, 4));
        2, 3, 4: set_window($urandom_range(5, 40));
        5: set_window($urandom_range(1, WIN_MAX));
        6: set_window(0);
        default: set_window(WIN_MAX);
      endcase
      case ($urandom_range(0, 7))
        0: set_offset(sample_t'($urandom()));
        1: set_offset($urandom_range(0, 1) ? S_MAX : S_MIN);
        default: set_offset(0);
      endcase
      steady_flow = ($urandom_range(0, 3) == 0);
      dc = sample_t'($urandom());
      n = $urandom_range(20, 50);
      repeat (n) send_sample(pick_sample(dc));
      sent += n;
      // sender holds off until every owed result has come back
      wait_results_drained();
      steady_flow = 1'b0;
    end
  endtask

  initial begin : main
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mean_tracking();
    test_fixed_offset();
    test_window_limits();
    test_random_traffic();
    wait_results_drained();
    repeat (60) @(posedge clk_i);
    if (expected_corrected.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_corrected.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/rmdc_pkg.sv
hdl/rmdc_serdiv.sv
hdl/running_mean_dc_offset_remover.sv
hdl/rmdc_checker.sv
verif/testbench.sv
